[hw/rtl/crsf_channel_frame_encoder_macros.svh]
// Assertion helpers for the frame encoder
`ifndef CRSF_CHANNEL_FRAME_ENCODER_MACROS_SVH
`define CRSF_CHANNEL_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define CRSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crsf assertion failed");

// next-cycle implication
`define CRSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crsf assertion failed");

`endif

[hw/rtl/crsf_pkg.sv]
`timescale 1ns / 1ps
package crsf_pkg;

  localparam int ChanW        = 11;
  localparam int ByteW        = 8;
  localparam int NUM_CHANNELS = 16;

  localparam logic [ByteW-1:0] FRAME_SYNC = 8'hC8;
  localparam logic [ByteW-1:0] LEN_BYTE   = 8'd24;
  localparam logic [ByteW-1:0] TYPE_BYTE  = 8'h16;
  localparam logic [ByteW-1:0] CRC_POLY   = 8'hD5;

  localparam logic [ChanW-1:0] DEFAULT_CHAN = 11'd992;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_LOAD,
    ST_BYTE,
    ST_CRC
  } state_t;

endpackage

[hw/rtl/crsf_if.sv]
`timescale 1ns / 1ps
interface crsf_in_if;
  logic                        valid;
  logic                        ready;
  logic [crsf_pkg::ChanW-1:0]  chan_val;
  logic                        last_channel;

  modport source (output valid, output chan_val, output last_channel, input ready);
  modport sink   (input valid, input chan_val, input last_channel, output ready);
endinterface

interface crsf_out_if;
  logic                        valid;
  logic                        ready;
  logic [crsf_pkg::ByteW-1:0]  frame_byte;
  logic                        frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

[hw/rtl/crsf_crc8.sv]
`timescale 1ns / 1ps
module crsf_crc8 (
  input  logic [crsf_pkg::ByteW-1:0] crc_in,
  input  logic [crsf_pkg::ByteW-1:0] data_in,
  output logic [crsf_pkg::ByteW-1:0] crc_out
);

  // MSB-first, one polynomial step per bit
  always_comb begin
    logic [crsf_pkg::ByteW-1:0] c;
    c = crc_in ^ data_in;
    for (int k = 0; k < crsf_pkg::ByteW; k++) begin
      if (c[crsf_pkg::ByteW-1]) begin
        c = (c << 1) ^ crsf_pkg::CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    crc_out = c;
  end

endmodule

[hw/rtl/crsf_channel_frame_encoder.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                          Handshake
// in_ch     in   chan_val[10:0], last_channel      valid/ready
// out_ch    out  frame_byte[7:0], frame_end        valid/ready
// cfg       in   cfg_wdata[10:0]                  cfg_we
//
// Each channel: accept, pack, send one or two bytes, close check. The first
// channel of a frame adds sync, length and type; each default fill channel
// adds one or two bytes; one CRC-8 unit over type and payload ends the frame.
// Reset is synchronous, active low; the default value returns to 992.
// A stalled out_ch holds the sequencer; in_ch is ready only between channels.
`include "crsf_channel_frame_encoder_macros.svh"
module crsf_channel_frame_encoder #(
  parameter int NUM_CHANNELS = crsf_pkg::NUM_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  crsf_in_if.sink                    in_ch,
  crsf_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [crsf_pkg::ChanW-1:0] cfg_wdata
);

  localparam int ChanW = crsf_pkg::ChanW;
  localparam int ByteW = crsf_pkg::ByteW;
  localparam int AccW  = ChanW + ByteW - 1;
  localparam int CntW  = $clog2(AccW + 1);
  localparam int IdxW  = $clog2(NUM_CHANNELS + 1);

  crsf_pkg::state_t state_r, state_nxt;

  logic [ChanW-1:0] dflt_r;
  logic [ChanW-1:0] val_r, val_nxt;
  logic             last_r, last_nxt;
  logic             fill_r, fill_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [ByteW-1:0] crc_r, crc_nxt;
  logic [1:0]       hdr_r, hdr_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [ByteW-1:0] obyte_r, obyte_nxt;
  logic             oend_r, oend_nxt;

  logic [ByteW-1:0] crc_in, crc_data, crc_out;
  logic             slot_free;
  logic [ChanW-1:0] pack_val;
  logic [ByteW-1:0] hdr_byte;
  logic             full;

  crsf_crc8 u_crc (
    .crc_in  (crc_in),
    .data_in (crc_data),
    .crc_out (crc_out)
  );

  assign slot_free = !ovalid_r || out_ch.ready;
  assign pack_val  = fill_r ? dflt_r : val_r;
  assign full      = (idx_r == IdxW'(NUM_CHANNELS));

  assign in_ch.ready       = (state_r == crsf_pkg::ST_IDLE);
  assign out_ch.valid      = ovalid_r;
  assign out_ch.frame_byte = obyte_r;
  assign out_ch.frame_end  = oend_r;

  always_comb begin
    case (hdr_r)
      2'd0:    hdr_byte = crsf_pkg::FRAME_SYNC;
      2'd1:    hdr_byte = crsf_pkg::LEN_BYTE;
      default: hdr_byte = crsf_pkg::TYPE_BYTE;
    endcase
  end

  always_comb begin
    if (state_r == crsf_pkg::ST_HDR) begin
      crc_in   = '0;
      crc_data = crsf_pkg::TYPE_BYTE;
    end else begin
      crc_in   = crc_r;
      crc_data = acc_r[ByteW-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    val_nxt    = val_r;
    last_nxt   = last_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    hdr_nxt    = hdr_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    obyte_nxt  = obyte_r;
    oend_nxt   = oend_r;

    case (state_r)
      crsf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          val_nxt  = in_ch.chan_val;
          last_nxt = in_ch.last_channel;
          hdr_nxt  = '0;
          state_nxt = (idx_r == '0) ? crsf_pkg::ST_HDR : crsf_pkg::ST_LOAD;
        end
      end
      crsf_pkg::ST_HDR: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = hdr_byte;
          oend_nxt   = 1'b0;
          hdr_nxt    = hdr_r + 2'd1;
          if (hdr_r == 2'd2) begin
            crc_nxt   = crc_out;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = crsf_pkg::ST_LOAD;
          end
        end
      end
      crsf_pkg::ST_LOAD: begin
        acc_nxt   = (acc_r & AccW'({(ByteW-1){1'b1}}))
                  | (AccW'(pack_val) << cnt_r[2:0]);
        cnt_nxt   = cnt_r + CntW'(ChanW);
        idx_nxt   = idx_r + IdxW'(1);
        state_nxt = crsf_pkg::ST_BYTE;
      end
      crsf_pkg::ST_BYTE: begin
        if (cnt_r >= CntW'(ByteW)) begin
          if (slot_free) begin
            ovalid_nxt = 1'b1;
            obyte_nxt  = acc_r[ByteW-1:0];
            oend_nxt   = 1'b0;
            crc_nxt    = crc_out;
            acc_nxt    = acc_r >> ByteW;
            cnt_nxt    = cnt_r - CntW'(ByteW);
          end
        end else if (full) begin
          state_nxt = crsf_pkg::ST_CRC;
        end else if (last_r || fill_r) begin
          fill_nxt  = 1'b1;
          state_nxt = crsf_pkg::ST_LOAD;
        end else begin
          state_nxt = crsf_pkg::ST_IDLE;
        end
      end
      crsf_pkg::ST_CRC: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = crc_r;
          oend_nxt   = 1'b1;
          idx_nxt    = '0;
          acc_nxt    = '0;
          cnt_nxt    = '0;
          crc_nxt    = '0;
          fill_nxt   = 1'b0;
          state_nxt  = crsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = crsf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= crsf_pkg::ST_IDLE;
      dflt_r   <= crsf_pkg::DEFAULT_CHAN;
      fill_r   <= 1'b0;
      idx_r    <= '0;
      acc_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= '0;
      hdr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        dflt_r <= cfg_wdata;
      end
      fill_r   <= fill_nxt;
      idx_r    <= idx_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      hdr_r    <= hdr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    last_r  <= last_nxt;
    obyte_r <= obyte_nxt;
    oend_r  <= oend_nxt;
  end

  `CRSF_ASSERT_IMPLY(a_end_clears_idx, clk, rst_n, out_ch.valid && out_ch.frame_end, idx_r == '0)
  `CRSF_ASSERT_IMPLY(a_idx_bound, clk, rst_n, 1'b1, idx_r <= IdxW'(NUM_CHANNELS))
  `CRSF_ASSERT_NEXT(a_first_hdr, clk, rst_n, in_ch.valid && in_ch.ready && idx_r == '0, state_r == crsf_pkg::ST_HDR)
  `CRSF_ASSERT_IMPLY(a_fill_closes, clk, rst_n, state_r == crsf_pkg::ST_IDLE, !fill_r && cnt_r < CntW'(ByteW))

endmodule
